// ----- rtl/btint_pkg.sv -----
package btint_pkg;

  localparam int E_POINTS_MAX  = 128;
  localparam int NB_POINTS_MAX = 128;
  localparam int VALUE_WIDTH   = 32;
  localparam int IDX_W         = 7;
  localparam int NUM_VALUES    = 4;
  localparam int NUM_BANKS     = 4;
  localparam int REC_W         = NUM_VALUES * VALUE_WIDTH;
  localparam int ADDR_W        = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH    = 1 << ADDR_W;
  localparam int FIFO_DEPTH    = 4;
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int FRAC_W        = 16;
  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

  typedef enum logic [1:0] {
    CFG_E_STEP_RECIP  = 2'd0,
    CFG_NB_STEP_RECIP = 2'd1,
    CFG_E_POINTS      = 2'd2,
    CFG_NB_POINTS     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // one queued operation, either a record write or a classified lookup
  typedef struct packed {
    logic                              lookup;
    logic                              oor;
    logic [FRAC_W-1:0]                 ae;
    logic [FRAC_W-1:0]                 an;
    logic                              pe;
    logic                              pn;
    logic [NUM_BANKS-1:0][ADDR_W-1:0]  addr;
    logic [1:0]                        wbank;
    logic [REC_W-1:0]                  wdata;
  } entry_t;

endpackage

// ----- rtl/btint_fifo.sv -----
module btint_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  btint_pkg::entry_t     push_data_i,
  input  logic                  pop_i,
  output logic                  not_empty_o,
  output btint_pkg::entry_t     pop_data_o,
  output logic [btint_pkg::CNT_W-1:0] count_o
);
  import btint_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  entry_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rptr_q];
  assign count_o     = cnt_q;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule

// ----- rtl/btint_front.sv -----
module btint_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [btint_pkg::IDX_W-1:0]   entry_e_index_i,
  input  logic [btint_pkg::IDX_W-1:0]   entry_nb_index_i,
  input  logic [btint_pkg::REC_W-1:0]   entry_record_i,
  input  logic signed [31:0]            energy_density_i,
  input  logic signed [31:0]            baryon_density_i,
  input  logic [btint_pkg::CNT_W-1:0]   fifo_count_i,
  output logic                          push_o,
  output btint_pkg::entry_t             push_data_o
);
  import btint_pkg::*;

  logic [31:0]       e_recip_q, nb_recip_q;
  logic [7:0]        e_points_q, nb_points_q;
  logic              v_q, cmd_q, neg_e_q, neg_n_q;
  logic [IDX_W-1:0]  ei_q, ni_q;
  logic [REC_W-1:0]  rec_q;
  logic [62:0]       prod_e_q, prod_n_q;
  logic              accept;
  logic [7:0]        ne, nn, re, rn;
  logic [30:0]       ie, inb;
  logic [IDX_W-1:0]  ie7, in7;
  logic              pe, pn;
  entry_t            ent;

  // room for every item already past the input register
  assign in_stall_o = ({1'b0, fifo_count_i} + (CNT_W + 1)'(v_q)) >= (CNT_W + 1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_recip_q   <= 32'd65536;
      nb_recip_q  <= 32'd65536;
      e_points_q  <= 8'd128;
      nb_points_q <= 8'd128;
      v_q         <= 1'b0;
    end else begin
      v_q <= accept;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_E_STEP_RECIP:  e_recip_q   <= cfg_data_i;
          CFG_NB_STEP_RECIP: nb_recip_q  <= cfg_data_i;
          CFG_E_POINTS:      e_points_q  <= cfg_data_i[7:0];
          CFG_NB_POINTS:     nb_points_q <= cfg_data_i[7:0];
          default:           ;
        endcase
      end
    end
  end

  // coordinate scaling, one multiplier per axis
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      ei_q     <= entry_e_index_i;
      ni_q     <= entry_nb_index_i;
      rec_q    <= entry_record_i;
      neg_e_q  <= energy_density_i[31];
      neg_n_q  <= baryon_density_i[31];
      prod_e_q <= 63'(energy_density_i[30:0]) * 63'(e_recip_q);
      prod_n_q <= 63'(baryon_density_i[30:0]) * 63'(nb_recip_q);
    end
  end

  // classify and work out the four bank addresses, or the write bank and address
  always_comb begin
    ne  = (e_points_q > 8'(E_POINTS_MAX)) ? 8'(E_POINTS_MAX) : e_points_q;
    nn  = (nb_points_q > 8'(NB_POINTS_MAX)) ? 8'(NB_POINTS_MAX) : nb_points_q;
    ie  = prod_e_q[62:32];
    inb = prod_n_q[62:32];
    ie7 = ie[IDX_W-1:0];
    in7 = inb[IDX_W-1:0];
    ent = '0;
    ent.lookup = (cmd_q == CMD_LOOKUP);
    ent.wdata  = rec_q;
    ent.ae     = prod_e_q[31:16];
    ent.an     = prod_n_q[31:16];
    ent.oor    = neg_e_q || neg_n_q || (ne < 8'd2) || (nn < 8'd2) ||
                 (ie >= 31'(ne - 8'd1)) || (inb >= 31'(nn - 8'd1));
    if (ent.lookup) begin
      ent.pe = ie7[0];
      ent.pn = in7[0];
      for (int b = 0; b < NUM_BANKS; b++) begin
        pe = b[1];
        pn = b[0];
        re = {1'b0, ie7} + 8'(pe ^ ie7[0]);
        rn = {1'b0, in7} + 8'(pn ^ in7[0]);
        ent.addr[b] = {re[IDX_W-1:1], rn[IDX_W-1:1]};
      end
    end else begin
      pe = 1'b0;
      pn = 1'b0;
      re = '0;
      rn = '0;
      ent.wbank = {ei_q[0], ni_q[0]};
      for (int b = 0; b < NUM_BANKS; b++) begin
        ent.addr[b] = {ei_q[IDX_W-1:1], ni_q[IDX_W-1:1]};
      end
    end
  end

  assign push_o      = v_q;
  assign push_data_o = ent;
endmodule

// ----- rtl/btint_back.sv -----
module btint_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        not_empty_i,
  input  btint_pkg::entry_t           pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [btint_pkg::REC_W-1:0] out_record_o,
  output logic                        out_of_range_o
);
  import btint_pkg::*;

  typedef logic signed [49:0] prod1_t;
  typedef logic signed [67:0] prod2_t;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic oor1_q, oor2_q, oor3_q, oor4_q, oor_q;
  logic [FRAC_W-1:0] ae1_q, an1_q, ae2_q, ae3_q;
  logic pe1_q, pn1_q;
  logic [REC_W-1:0] rd_q [NUM_BANKS];
  prod1_t p4_q [NUM_VALUES], p2_q [NUM_VALUES], p3_q [NUM_VALUES], p1_q [NUM_VALUES];
  prod1_t hi_q [NUM_VALUES], lo_q [NUM_VALUES];
  prod2_t wh_q [NUM_VALUES], wl_q [NUM_VALUES];
  logic [REC_W-1:0] res_q;

  assign adv   = !ov_q || !out_stall_i;
  assign pop_o = adv && not_empty_i;

  // four banks split by index parity so each cell corner has its own port
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [REC_W-1:0] mem [BANK_DEPTH];
    logic             wen;
    assign wen = pop_o && !pop_data_i.lookup && (pop_data_i.wbank == 2'(b));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (wen) begin
          mem[pop_data_i.addr[b]] <= pop_data_i.wdata;
        end
        rd_q[b] <= mem[pop_data_i.addr[b]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o && pop_data_i.lookup;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor1_q <= pop_data_i.oor;
      ae1_q  <= pop_data_i.ae;
      an1_q  <= pop_data_i.an;
      pe1_q  <= pop_data_i.pe;
      pn1_q  <= pop_data_i.pn;
      oor2_q <= oor1_q;
      ae2_q  <= ae1_q;
      oor3_q <= oor2_q;
      ae3_q  <= ae2_q;
      oor4_q <= oor3_q;
      oor_q  <= oor4_q;
    end
  end

  // corner weighting along the baryon axis, then the energy axis
  always_ff @(posedge clk_i) begin
    logic signed [17:0] wa, wb, we, wf;
    logic [REC_W-1:0]   s1, s2, s3, s4;
    logic signed [64:0] sum;
    wa = $signed({2'b00, an1_q});
    wb = $signed({1'b0, FRAC_ONE - {1'b0, an1_q}});
    we = $signed({2'b00, ae3_q});
    wf = $signed({1'b0, FRAC_ONE - {1'b0, ae3_q}});
    s1 = rd_q[{pe1_q, pn1_q}];
    s2 = rd_q[{~pe1_q, pn1_q}];
    s3 = rd_q[{pe1_q, ~pn1_q}];
    s4 = rd_q[{~pe1_q, ~pn1_q}];
    if (adv) begin
      for (int k = 0; k < NUM_VALUES; k++) begin
        p4_q[k] <= wa * $signed(s4[k*VALUE_WIDTH +: VALUE_WIDTH]);
        p2_q[k] <= wb * $signed(s2[k*VALUE_WIDTH +: VALUE_WIDTH]);
        p3_q[k] <= wa * $signed(s3[k*VALUE_WIDTH +: VALUE_WIDTH]);
        p1_q[k] <= wb * $signed(s1[k*VALUE_WIDTH +: VALUE_WIDTH]);
        hi_q[k] <= p4_q[k] + p2_q[k];
        lo_q[k] <= p3_q[k] + p1_q[k];
        wh_q[k] <= we * hi_q[k];
        wl_q[k] <= wf * lo_q[k];
        // round to nearest, ties up
        sum = 65'(wh_q[k]) + 65'(wl_q[k]) + 65'(64'h8000_0000);
        res_q[k*VALUE_WIDTH +: VALUE_WIDTH] <= oor4_q ? '0 : sum[63:32];
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign out_record_o   = res_q;
  assign out_of_range_o = oor_q;
endmodule

// ----- rtl/bilinear_table_interpolator.sv -----
// bilinear table interpolator: 128 x 128 grid of four-value records
// path: input register, queue, bank read, weighting registers, result
// throughput: one item per cycle, writes and lookups alike, when not stalled,
//   set by the four parity-banked single-port corner memories read in parallel
// reset: rst_ni async active low clears control and restores registers;
//   table contents stay undefined until written, no clearing pass
module bilinear_table_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [6:0]          entry_e_index_i,
  input  logic [6:0]          entry_nb_index_i,
  input  logic signed [31:0]  entry_pressure_i,
  input  logic signed [31:0]  entry_temperature_i,
  input  logic signed [31:0]  entry_baryon_potential_i,
  input  logic signed [31:0]  entry_strange_potential_i,
  input  logic signed [31:0]  energy_density_i,
  input  logic signed [31:0]  baryon_density_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pressure_o,
  output logic signed [31:0]  temperature_o,
  output logic signed [31:0]  baryon_potential_o,
  output logic signed [31:0]  strange_potential_o,
  output logic                out_of_range_o
);
  import btint_pkg::*;

  logic             push, pop, not_empty;
  entry_t           push_data, pop_data;
  logic [CNT_W-1:0] fifo_count;
  logic [REC_W-1:0] out_record;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // front: scales coordinates, checks range, picks bank addresses
  btint_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .entry_e_index_i  (entry_e_index_i),
    .entry_nb_index_i (entry_nb_index_i),
    .entry_record_i   ({entry_strange_potential_i, entry_baryon_potential_i,
                        entry_temperature_i, entry_pressure_i}),
    .energy_density_i (energy_density_i),
    .baryon_density_i (baryon_density_i),
    .fifo_count_i     (fifo_count),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  // short queue decouples front from output back-pressure
  btint_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (pop_data),
    .count_o     (fifo_count)
  );

  // back: memory access and the interpolation pipeline
  btint_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .not_empty_i    (not_empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_record_o   (out_record),
    .out_of_range_o (out_of_range_o)
  );

  assign pressure_o          = out_record[0*VALUE_WIDTH +: VALUE_WIDTH];
  assign temperature_o       = out_record[1*VALUE_WIDTH +: VALUE_WIDTH];
  assign baryon_potential_o  = out_record[2*VALUE_WIDTH +: VALUE_WIDTH];
  assign strange_potential_o = out_record[3*VALUE_WIDTH +: VALUE_WIDTH];
endmodule

// ----- rtl/btint_checker.sv -----
module btint_assert (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] pressure_o,
  input logic signed [31:0] temperature_o,
  input logic signed [31:0] baryon_potential_o,
  input logic signed [31:0] strange_potential_o,
  input logic               out_of_range_o
);

  // out of range results carry zero values
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |->
      (pressure_o == 0 && temperature_o == 0 &&
       baryon_potential_o == 0 && strange_potential_o == 0))
    else $error("out of range result with nonzero value");

  // held result keeps its pressure value and range flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pressure_o) && $stable(out_of_range_o)))
    else $error("stalled result changed");

  // no result while reset is asserted
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind bilinear_table_interpolator btint_assert u_btint_checker (.*);
